### rtl/slbc_pkg.sv
// Package for the status LED blink code unit.
// Holds mode codes, register indexes and field widths; depends on nothing.
`default_nettype none

package slbc_pkg;

    localparam int MODE_W  = 3;
    localparam int DUR_W   = 16;
    localparam int COUNT_W = 3;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [DUR_W-1:0]   dur_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Mode codes, shared by the command field and the result field.
    localparam mode_t MODE_OFF   = 3'd0;
    localparam mode_t MODE_ON    = 3'd1;
    localparam mode_t MODE_FAST  = 3'd2;
    localparam mode_t MODE_CODE1 = 3'd3;
    localparam mode_t MODE_CODE4 = 3'd6;

    // Input kinds carried on tuser.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_MODE = 1'b1;

    // Register indexes; the byte address is four times the index.
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_FAST_TOGGLE = 3'd0;
    localparam reg_idx_t REG_PULSE_ON    = 3'd1;
    localparam reg_idx_t REG_PULSE_GAP   = 3'd2;
    localparam reg_idx_t REG_CODE_PAUSE  = 3'd3;
    localparam reg_idx_t REG_ACTIVE_HIGH = 3'd4;

    localparam dur_t RST_FAST_TOGGLE = 16'd100;
    localparam dur_t RST_PULSE_ON    = 16'd200;
    localparam dur_t RST_PULSE_GAP   = 16'd200;
    localparam dur_t RST_CODE_PAUSE  = 16'd1000;

endpackage

`default_nettype wire

### rtl/status_led_blink_code_unit.sv
// Status LED blink code unit: mode register, elapsed counter and result register.
// Depends on slbc_pkg for mode codes, register indexes and widths.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | tuser: action; tdata: new_mode
//   m_axis   | out       | tdata: pin_level, lit, mode_now
//   apb      | in/out    | five duration/polarity registers at 4*index
//
// The state update is one saturating add and one compare against a selected
// duration, written straight into the result register.
// A new beat is taken every cycle while the result register is empty or drains.
// Reset (aresetn low, synchronous) gives mode off, LED dark and default registers.
// A stalled result holds the input side only while that register stays full.
`default_nettype none

module status_led_blink_code_unit #(
    parameter int TIME_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [2:0] new_mode, [7:3] zero
    input  wire logic        s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] pin_level, [1] lit, [4:2] mode_now, [7:5] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import slbc_pkg::*;

    // Compare width covers both the counter and the 16-bit durations.
    localparam int CMP_W = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

    typedef logic [TIME_WIDTH-1:0] time_t;

    dur_t   fast_toggle_reg, pulse_on_reg, pulse_gap_reg, code_pause_reg;
    logic   active_high_reg;

    mode_t  mode_reg, mode_next;
    time_t  elapsed_reg, elapsed_next;
    count_t pulse_count_reg, pulse_count_next;
    logic   lit_reg, lit_next;

    logic       out_valid_reg;
    logic [7:0] out_data_reg, out_data_next;

    logic     s_accept, cfg_write;
    reg_idx_t cfg_idx;
    time_t    elapsed_inc;
    dur_t     limit;
    logic     limit_hit;
    count_t   target;
    mode_t    cmd_mode;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_toggle_reg <= RST_FAST_TOGGLE;
            pulse_on_reg    <= RST_PULSE_ON;
            pulse_gap_reg   <= RST_PULSE_GAP;
            code_pause_reg  <= RST_CODE_PAUSE;
            active_high_reg <= 1'b1;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_FAST_TOGGLE: fast_toggle_reg <= pwdata[DUR_W-1:0];
                REG_PULSE_ON:    pulse_on_reg    <= pwdata[DUR_W-1:0];
                REG_PULSE_GAP:   pulse_gap_reg   <= pwdata[DUR_W-1:0];
                REG_CODE_PAUSE:  code_pause_reg  <= pwdata[DUR_W-1:0];
                REG_ACTIVE_HIGH: active_high_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FAST_TOGGLE: prdata = {16'd0, fast_toggle_reg};
            REG_PULSE_ON:    prdata = {16'd0, pulse_on_reg};
            REG_PULSE_GAP:   prdata = {16'd0, pulse_gap_reg};
            REG_CODE_PAUSE:  prdata = {16'd0, code_pause_reg};
            REG_ACTIVE_HIGH: prdata = {31'd0, active_high_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Input side is free whenever the result register is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cmd_mode = s_tdata[MODE_W-1:0];

    // Pulses wanted by the current blink code: code 1 is mode three.
    assign target = COUNT_W'(mode_reg - MODE_CODE1 + mode_t'(1));

    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + time_t'(1);

    always_comb begin
        if (mode_reg == MODE_FAST)
            limit = fast_toggle_reg;
        else if (lit_reg)
            limit = pulse_on_reg;
        else if (pulse_count_reg >= target)
            limit = code_pause_reg;
        else
            limit = pulse_gap_reg;
    end

    assign limit_hit = CMP_W'(elapsed_inc) >= CMP_W'(limit);

    always_comb begin
        mode_next        = mode_reg;
        elapsed_next     = elapsed_reg;
        pulse_count_next = pulse_count_reg;
        lit_next         = lit_reg;
        if (s_tuser == ACT_MODE) begin
            if (cmd_mode <= MODE_CODE4 && cmd_mode != mode_reg) begin
                mode_next        = cmd_mode;
                elapsed_next     = '0;
                pulse_count_next = '0;
                lit_next         = (cmd_mode != MODE_OFF);
            end
        end else begin
            elapsed_next = elapsed_inc;
            if (mode_reg == MODE_FAST) begin
                if (limit_hit) begin
                    elapsed_next = '0;
                    lit_next     = !lit_reg;
                end
            end else if (mode_reg >= MODE_CODE1) begin
                if (limit_hit) begin
                    elapsed_next = '0;
                    if (lit_reg) begin
                        lit_next         = 1'b0;
                        pulse_count_next = pulse_count_reg + count_t'(1);
                    end else begin
                        lit_next = 1'b1;
                        if (pulse_count_reg >= target)
                            pulse_count_next = '0;
                    end
                end
            end
        end
    end

    always_comb begin
        out_data_next = {3'd0, mode_next, lit_next, lit_next ^ !active_high_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_OFF;
            elapsed_reg     <= '0;
            pulse_count_reg <= '0;
            lit_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg        <= mode_next;
                elapsed_reg     <= elapsed_next;
                pulse_count_reg <= pulse_count_next;
                lit_reg         <= lit_next;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // The pulse count stays within the current code, and is zero outside blink modes.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg >= MODE_CODE1) |-> (pulse_count_reg <= target))
        else $error("pulse count beyond code length");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg < MODE_CODE1) |-> (pulse_count_reg == '0))
        else $error("pulse count set outside blink modes");

    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_OFF) |-> !lit_reg)
        else $error("LED lit in off mode");

    a_mode_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == ACT_MODE && cmd_mode <= MODE_CODE4 && cmd_mode != mode_reg)
        |=> (elapsed_reg == '0 && mode_reg == $past(cmd_mode)))
        else $error("mode change did not restart timing");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tvalid && m_tdata[4:2] == mode_reg && m_tdata[1] == lit_reg))
        else $error("result register does not match state");
`endif

endmodule

`default_nettype wire

### verif/status_led_blink_code_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the status LED blink code unit. It watches the stream and APB ports,
// predicts every result beat and compares each one with the oldest prediction.
// Depends on slbc_pkg for mode codes, register indexes and the duration width.
module status_led_blink_code_unit_checker #(
    parameter int TIME_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [2:0] new_mode, [7:3] zero
    input  wire logic        s_tuser,   // [0] action
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [0] pin_level, [1] lit, [4:2] mode_now, [7:5] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               mismatch_count,
    output int               pending_results,
    output int               results_checked
);
    import slbc_pkg::*;

    typedef struct packed {
        logic  pin_level;
        logic  lit;
        mode_t mode_now;
    } led_view_t;

    // Register copies, tracked from the APB writes the block sees.
    dur_t fast_ms;
    dur_t on_ms;
    dur_t gap_ms;
    dur_t pause_ms;
    logic pol_high;

    // Pattern state.
    mode_t                 mode_q;
    logic [TIME_WIDTH-1:0] elapsed_q;
    count_t                pulses_q;
    logic                  lit_q;

    led_view_t predicted_leds[$];

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // One command or one millisecond tick, applied to the pattern state.
    task automatic advance_pattern(input logic action, input mode_t cmd);
        count_t target;
        if (action == ACT_MODE) begin
            if (cmd <= MODE_CODE4 && cmd != mode_q) begin
                mode_q    = cmd;
                pulses_q  = '0;
                elapsed_q = '0;
                lit_q     = (cmd != MODE_OFF);
            end
        end else begin
            if (elapsed_q != '1) begin
                elapsed_q = elapsed_q + 1'b1;
            end
            if (mode_q == MODE_FAST) begin
                if (elapsed_q >= fast_ms) begin
                    elapsed_q = '0;
                    lit_q     = ~lit_q;
                end
            end else if (mode_q >= MODE_CODE1) begin
                target = mode_q - MODE_CODE1 + 3'd1;
                if (lit_q) begin
                    if (elapsed_q >= on_ms) begin
                        elapsed_q = '0;
                        lit_q     = 1'b0;
                        pulses_q  = pulses_q + 1'b1;
                    end
                end else if (pulses_q >= target) begin
                    // The full code has been shown, so wait out the long pause.
                    if (elapsed_q >= pause_ms) begin
                        elapsed_q = '0;
                        pulses_q  = '0;
                        lit_q     = 1'b1;
                    end
                end else if (elapsed_q >= gap_ms) begin
                    elapsed_q = '0;
                    lit_q     = 1'b1;
                end
            end
        end
        predicted_leds.push_back('{pin_level: pol_high ? lit_q : ~lit_q,
                                   lit: lit_q, mode_now: mode_q});
    endtask

    always @(posedge aclk) begin
        led_view_t want;
        led_view_t got;
        if (!aresetn) begin
            fast_ms         = RST_FAST_TOGGLE;
            on_ms           = RST_PULSE_ON;
            gap_ms          = RST_PULSE_GAP;
            pause_ms        = RST_CODE_PAUSE;
            pol_high        = 1'b1;
            mode_q          = MODE_OFF;
            elapsed_q       = '0;
            pulses_q        = '0;
            lit_q           = 1'b0;
            predicted_leds.delete();
            pending_results = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_FAST_TOGGLE: fast_ms  = pwdata[DUR_W-1:0];
                    REG_PULSE_ON:    on_ms    = pwdata[DUR_W-1:0];
                    REG_PULSE_GAP:   gap_ms   = pwdata[DUR_W-1:0];
                    REG_CODE_PAUSE:  pause_ms = pwdata[DUR_W-1:0];
                    REG_ACTIVE_HIGH: pol_high = pwdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = '{pin_level: m_tdata[0], lit: m_tdata[1], mode_now: m_tdata[4:2]};
                if (predicted_leds.size() == 0) begin
                    flag_error($sformatf("result beat with none predicted: pin %b lit %b mode %0d",
                                         got.pin_level, got.lit, got.mode_now));
                end else begin
                    want = predicted_leds.pop_front();
                    results_checked++;
                    if (got.pin_level !== want.pin_level || got.lit !== want.lit ||
                        got.mode_now !== want.mode_now) begin
                        flag_error($sformatf(
                            "result %0d: pin %b/%b lit %b/%b mode %0d/%0d (expected/actual)",
                            results_checked, want.pin_level, got.pin_level, want.lit, got.lit,
                            want.mode_now, got.mode_now));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_pattern(s_tuser, s_tdata[MODE_W-1:0]);
            end
            pending_results = predicted_leds.size();
        end
    end

endmodule

### verif/status_led_blink_code_unit_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the status LED blink code unit: clock, reset, stimulus
// and verdict. Depends on slbc_pkg, the unit itself and status_led_blink_code_unit_checker.
module status_led_blink_code_unit_tb;
    import slbc_pkg::*;

    localparam int TIME_WIDTH    = 16;
    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 70;
    localparam int LONG_TICKS    = 20;

    localparam mode_t MODE_CODE2 = MODE_CODE1 + 3'd1;
    localparam mode_t MODE_UNDEF = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    wire logic   s_tready;
    logic [7:0]  s_tdata;   // [2:0] new_mode, [7:3] zero
    logic        s_tuser;   // [0] action
    wire logic   m_tvalid;
    logic        m_tready;
    wire logic [7:0] m_tdata;  // [0] pin_level, [1] lit, [4:2] mode_now, [7:5] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    wire logic [31:0] prdata;
    wire logic   pready;

    int src_idle_pct;
    int sink_stall_pct;
    int holds_asked;
    int holds_done;
    int reg_writes;
    int cycle_count;
    int mismatch_count;
    int pending_results;
    int results_checked;

    status_led_blink_code_unit #(.TIME_WIDTH(TIME_WIDTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    status_led_blink_code_unit_checker #(.TIME_WIDTH(TIME_WIDTH)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatch_count(mismatch_count), .pending_results(pending_results),
        .results_checked(results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status_led_blink_code_unit_tb NOT OK");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked for.
    initial begin : result_sink
        m_tready   = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (holds_done != holds_asked) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Once raised, tvalid stays high until the beat is taken.
    task automatic send_beat(input logic action, input mode_t cmd);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {5'b0, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    task automatic write_settings(input dur_t fast, input dur_t on, input dur_t gap,
                                  input dur_t pause, input logic pol);
        write_reg(REG_FAST_TOGGLE, 32'(fast));
        write_reg(REG_PULSE_ON, 32'(on));
        write_reg(REG_PULSE_GAP, 32'(gap));
        write_reg(REG_CODE_PAUSE, 32'(pause));
        write_reg(REG_ACTIVE_HIGH, 32'(pol));
    endtask

    // A mode command followed by a burst of ticks, again and again, so the patterns get to run.
    // The mode field carries random junk on ticks, and commands may repeat or be undefined.
    task automatic random_sequences(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            send_beat(ACT_MODE, mode_t'($urandom_range(7)));
            burst = $urandom_range(30, 2);
            repeat (burst) send_beat(ACT_TICK, mode_t'($urandom_range(7)));
            sent += burst + 1;
        end
    endtask

    initial begin : stimulus
        int ph;
        int pick;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = ACT_TICK;
        s_tdata        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holds_asked    = 0;
        reg_writes     = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a tick while off, a repeated off, and the undefined code.
        send_beat(ACT_TICK, MODE_OFF);
        send_beat(ACT_MODE, MODE_OFF);
        send_beat(ACT_MODE, MODE_UNDEF);
        wait_drained();

        // Short periods, a zero gap and an inverted pin.
        write_settings(16'd2, 16'd1, 16'd0, 16'd3, 1'b0);
        send_beat(ACT_MODE, MODE_ON);
        send_beat(ACT_TICK, MODE_OFF);
        send_beat(ACT_MODE, MODE_ON);
        send_beat(ACT_MODE, MODE_FAST);
        repeat (3) send_beat(ACT_TICK, MODE_OFF);
        send_beat(ACT_MODE, MODE_CODE1);
        repeat (3) send_beat(ACT_TICK, MODE_OFF);
        send_beat(ACT_MODE, MODE_CODE4);
        repeat (10) send_beat(ACT_TICK, MODE_OFF);
        send_beat(ACT_MODE, MODE_OFF);

        // Hold the result side while beats keep coming, so the input side backs up.
        holds_asked++;
        send_beat(ACT_MODE, MODE_CODE2);
        repeat (40) send_beat(ACT_TICK, mode_t'($urandom_range(7)));
        wait_drained();

        // Full-range durations: over a short run of ticks the fast toggle never flips.
        write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_beat(ACT_MODE, MODE_FAST);
        repeat (LONG_TICKS) send_beat(ACT_TICK, MODE_OFF);
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase
            pick = (ph + ph / 4) % 4;
            case (pick)
                0: write_settings(dur_t'($urandom_range(6, 1)), dur_t'($urandom_range(6, 1)),
                                  dur_t'($urandom_range(6, 1)), dur_t'($urandom_range(6, 1)),
                                  1'(ph % 2));
                1: write_settings(16'd0, 16'd0, 16'd0, 16'd0, 1'(ph % 2));
                2: write_settings(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 1'(ph % 2));
                default: write_settings(dur_t'($urandom_range(20)), dur_t'($urandom_range(20)),
                                        dur_t'($urandom_range(20)), dur_t'($urandom_range(20)),
                                        1'(ph % 2));
            endcase
            random_sequences(PHASE_ITEMS / 2);
            if (ph == 3) begin
                // The sender stops until every result so far is back.
                wait_drained();
            end
            random_sequences(PHASE_ITEMS / 2);
            wait_drained();
        end
        repeat (4) @(negedge aclk);

        $display("Checked %0d result beats across %0d register writes: every mode, repeated",
                 results_checked, reg_writes);
        $display("and undefined commands, zero and full-range durations, four idle mixes.");
        if (mismatch_count == 0) begin
            $display("status_led_blink_code_unit_tb OK");
        end else begin
            $display("status_led_blink_code_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
